/* design/rso_pkg.sv */
// ----------------------------------------------------------------------------
// rso_pkg
// shared types, constants and helpers for the rectangle split occlusion core
// ----------------------------------------------------------------------------
package rso_pkg;

  // internal coordinate width: holds x + w and every difference of cuts
  localparam int CW = 19;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration reset values
  localparam logic [14:0] DISP_WIDTH_RST   = 15'd256;
  localparam logic [14:0] DISP_HEIGHT_RST  = 15'd192;
  localparam logic [14:0] UPPER_OFFSET_RST = 15'd192;

  typedef enum logic [1:0] {
    REG_DISP_WIDTH   = 2'd0,
    REG_DISP_HEIGHT  = 2'd1,
    REG_UPPER_OFFSET = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_REMAIN  = 2'd0,
    KIND_VISIBLE = 2'd1,
    KIND_NONE    = 2'd2
  } piece_kind_t;

  // one classified job: cut positions per axis and the overlap cell
  typedef struct packed {
    logic [3:0][CW-1:0] cx;
    logic [3:0][CW-1:0] cy;
    logic [1:0]         nx;
    logic [1:0]         ny;
    logic               ovx;
    logic               ovy;
    logic               overlap;
  } job_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    piece_kind_t kind;
    logic        last;
  } piece_t;

  function automatic logic [CW-1:0] sx16(input logic [15:0] v);
    return {{(CW-16){v[15]}}, v};
  endfunction

  function automatic logic [CW-1:0] zx15(input logic [14:0] v);
    return {{(CW-15){1'b0}}, v};
  endfunction

endpackage

/* design/rso_front.sv */
// ----------------------------------------------------------------------------
// rso_front
// overlap test and cut list construction for one incoming rectangle pair
// ----------------------------------------------------------------------------
module rso_front (
  input  logic [15:0]   rect_x,
  input  logic [15:0]   rect_y,
  input  logic [14:0]   rect_w,
  input  logic [14:0]   rect_h,
  input  logic [15:0]   occ_x,
  input  logic [15:0]   occ_y,
  input  logic [14:0]   occ_w,
  input  logic [14:0]   occ_h,
  output rso_pkg::job_t job
);

  typedef struct packed {
    logic [3:0][rso_pkg::CW-1:0] cut;
    logic [1:0]                  n;
    logic                        ov;
  } axis_t;

  // x axis takes the far occluder edge on <=, y axis only on <
  function automatic axis_t cut_axis(
    input logic signed [rso_pkg::CW-1:0] s,
    input logic signed [rso_pkg::CW-1:0] e,
    input logic signed [rso_pkg::CW-1:0] os,
    input logic signed [rso_pkg::CW-1:0] oe,
    input logic                          strict_third
  );
    axis_t                         a;
    logic                          lt;
    logic                          third;
    logic                          t;
    logic signed [rso_pkg::CW-1:0] c1;
    logic signed [rso_pkg::CW-1:0] lastc;
    lt    = s < os;
    c1    = lt ? os : ((oe <= e) ? oe : e);
    third = strict_third ? (oe < e) : (oe <= e);
    t     = third && (c1 != oe);
    lastc = t ? oe : c1;
    a.cut[0] = s;
    a.cut[1] = c1;
    a.cut[2] = t ? oe : e;
    a.cut[3] = e;
    a.ov     = lt;
    a.n      = 2'd1 + {1'b0, t} + {1'b0, lastc < e};
    return a;
  endfunction

  logic signed [rso_pkg::CW-1:0] rx, ry, ox, oy;
  logic signed [rso_pkg::CW-1:0] rxe, rye, oxe, oye;
  logic                          overlap;
  axis_t                         ax, ay;

  assign rx  = rso_pkg::sx16(rect_x);
  assign ry  = rso_pkg::sx16(rect_y);
  assign ox  = rso_pkg::sx16(occ_x);
  assign oy  = rso_pkg::sx16(occ_y);
  assign rxe = rx + $signed(rso_pkg::zx15(rect_w));
  assign rye = ry + $signed(rso_pkg::zx15(rect_h));
  assign oxe = ox + $signed(rso_pkg::zx15(occ_w));
  assign oye = oy + $signed(rso_pkg::zx15(occ_h));

  assign overlap = (rxe > ox) && (rye > oy) && (rx < oxe) && (ry < oye);

  assign ax = cut_axis(rx, rxe, ox, oxe, 1'b0);
  assign ay = cut_axis(ry, rye, oy, oye, 1'b1);

  always_comb begin
    job.overlap = overlap;
    if (overlap) begin
      job.cx  = ax.cut;
      job.cy  = ay.cut;
      job.nx  = ax.n;
      job.ny  = ay.n;
      job.ovx = ax.ov;
      job.ovy = ay.ov;
    end else begin
      // disjoint: a single cell that spans the whole input rectangle
      job.cx  = {rxe, rxe, rxe, rx};
      job.cy  = {rye, rye, rye, ry};
      job.nx  = 2'd1;
      job.ny  = 2'd1;
      job.ovx = 1'b0;
      job.ovy = 1'b0;
    end
  end

endmodule

/* design/rso_queue.sv */
// ----------------------------------------------------------------------------
// rso_queue
// small job queue between the front classifier and the back walker
// ----------------------------------------------------------------------------
module rso_queue #(
  parameter int DEPTH = rso_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rso_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rso_pkg::job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  rso_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full       = (count_r == NW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* design/rso_back.sv */
// ----------------------------------------------------------------------------
// rso_back
// walks the cells of one job, clips each to the screens and emits survivors
// ----------------------------------------------------------------------------
module rso_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [14:0]    disp_width,
  input  logic [14:0]    disp_height,
  input  logic [14:0]    upper_offset,
  input  logic           job_valid,
  input  rso_pkg::job_t  job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output rso_pkg::piece_t out_piece
);

  localparam int CW = rso_pkg::CW;

  // walker state
  logic                active_r, active_nxt;
  logic [1:0]          i_r, i_nxt, j_r, j_nxt;
  logic [1:0]          nx_r, nx_nxt, ny_r, ny_nxt;
  logic                ovx_r, ovx_nxt, ovy_r, ovy_nxt, ovl_r, ovl_nxt;
  logic [3:0][CW-1:0]  cxw_r, cxw_nxt, cyw_r, cyw_nxt, cys_r, cys_nxt;

  // held survivor and output register
  rso_pkg::piece_t     pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  rso_pkg::piece_t     out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  logic                out_free, step, load, cand_last, cand_keep, push;
  logic                in_screen;
  rso_pkg::piece_t     cand;
  logic signed [CW-1:0] x, x1, y, y1, sw, sh, off, offsh, w, h;

  assign out_free = !out_v_r || !out_stall;
  assign step     = active_r && out_free;
  assign cand_last = (i_r == nx_r - 2'd1) && (j_r == ny_r - 2'd1);
  assign load     = job_valid && (!active_r || (step && cand_last));
  assign job_pop  = load;

  assign x     = $signed(cxw_r[0]);
  assign x1    = $signed(cxw_r[1]);
  assign y     = $signed(cyw_r[0]);
  assign y1    = $signed(cyw_r[1]);
  assign sw    = $signed(rso_pkg::zx15(disp_width));
  assign sh    = $signed(rso_pkg::zx15(disp_height));
  assign off   = $signed(rso_pkg::zx15(upper_offset));
  assign offsh = off + sh;

  always_comb begin
    in_screen = (x < sw) && ((y < sh) || ((y >= off) && (y < offsh)));
    if (!ovl_r) begin
      h = y1 - y;
    end else if ((y1 > sh) && (y1 < off)) begin
      h = sh - y;
    end else if (y1 > offsh) begin
      h = offsh - y;
    end else begin
      h = y1 - y;
    end
    if (ovl_r && (x1 > sw)) begin
      w = sw - x;
    end else begin
      w = x1 - x;
    end
    cand_keep = !ovl_r || (in_screen && (h > 0) && (w > 0));
    cand.x    = x[15:0];
    cand.y    = y[15:0];
    cand.w    = w[14:0];
    cand.h    = h[14:0];
    cand.kind = (ovl_r && (i_r == {1'b0, ovx_r}) && (j_r == {1'b0, ovy_r})) ?
                rso_pkg::KIND_VISIBLE : rso_pkg::KIND_REMAIN;
    cand.last = cand_last;
  end

  // walker: one cell per cycle while the output is not stalled, column-major
  always_comb begin
    active_nxt = active_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    nx_nxt     = nx_r;
    ny_nxt     = ny_r;
    ovx_nxt    = ovx_r;
    ovy_nxt    = ovy_r;
    ovl_nxt    = ovl_r;
    cxw_nxt    = cxw_r;
    cyw_nxt    = cyw_r;
    cys_nxt    = cys_r;
    if (step) begin
      if (cand_last) begin
        active_nxt = 1'b0;
      end else if (j_r == ny_r - 2'd1) begin
        i_nxt   = i_r + 2'd1;
        j_nxt   = 2'd0;
        cxw_nxt = {cxw_r[3], cxw_r[3:1]};
        cyw_nxt = cys_r;
      end else begin
        j_nxt   = j_r + 2'd1;
        cyw_nxt = {cyw_r[3], cyw_r[3:1]};
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      i_nxt      = 2'd0;
      j_nxt      = 2'd0;
      nx_nxt     = job.nx;
      ny_nxt     = job.ny;
      ovx_nxt    = job.ovx;
      ovy_nxt    = job.ovy;
      ovl_nxt    = job.overlap;
      cxw_nxt    = job.cx;
      cyw_nxt    = job.cy;
      cys_nxt    = job.cy;
    end
  end

  // with the output free, a held survivor leaves once the next one shows up or its job is closed
  always_comb begin
    push       = out_free && pend_v_r && (pend_r.last || (step && cand_keep));
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    if (push) begin
      out_nxt   = pend_r;
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (step && cand_keep) begin
      pend_nxt   = cand;
      pend_v_nxt = 1'b1;
    end else if (step && cand_last) begin
      if (pend_v_r && !pend_r.last) begin
        pend_nxt.last = 1'b1;
      end else begin
        pend_nxt.x    = '0;
        pend_nxt.y    = '0;
        pend_nxt.w    = '0;
        pend_nxt.h    = '0;
        pend_nxt.kind = rso_pkg::KIND_NONE;
        pend_nxt.last = 1'b1;
        pend_v_nxt    = 1'b1;
      end
    end else if (push) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    ovx_r  <= ovx_nxt;
    ovy_r  <= ovy_nxt;
    ovl_r  <= ovl_nxt;
    cxw_r  <= cxw_nxt;
    cyw_r  <= cyw_nxt;
    cys_r  <= cys_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_piece = out_r;

endmodule

/* design/rectangle_split_occlusion_core.sv */
// ----------------------------------------------------------------------------
// rectangle_split_occlusion_core
// splits a rectangle at an occluder's edges and clips the pieces to two screens
// ----------------------------------------------------------------------------
// path: a transaction is stored in the job queue, loaded into the back walker,
//   held as the pending survivor and registered at the output; an item has
//   nx*ny cells (1 to 9), one clipped per cycle unless the output stalls
// reset: synchronous active-low rst_n empties the job queue, idles the walker,
//   drops the output and returns the screen registers to 256 / 192 / 192
module rectangle_split_occlusion_core #(
  parameter int QUEUE_DEPTH = rso_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_rect_x,
  input  logic [15:0] in_rect_y,
  input  logic [14:0] in_rect_w,
  input  logic [14:0] in_rect_h,
  input  logic [15:0] in_occ_x,
  input  logic [15:0] in_occ_y,
  input  logic [14:0] in_occ_w,
  input  logic [14:0] in_occ_h,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_piece_x,
  output logic [15:0] out_piece_y,
  output logic [14:0] out_piece_w,
  output logic [14:0] out_piece_h,
  output logic [1:0]  out_piece_kind,
  output logic        out_last_piece,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  // screen geometry registers
  logic [14:0] disp_width_r, disp_width_nxt;
  logic [14:0] disp_height_r, disp_height_nxt;
  logic [14:0] upper_offset_r, upper_offset_nxt;

  always_comb begin
    disp_width_nxt   = disp_width_r;
    disp_height_nxt  = disp_height_r;
    upper_offset_nxt = upper_offset_r;
    if (cfg_we) begin
      unique case (rso_pkg::cfg_reg_t'(cfg_index))
        rso_pkg::REG_DISP_WIDTH:   disp_width_nxt   = cfg_wdata;
        rso_pkg::REG_DISP_HEIGHT:  disp_height_nxt  = cfg_wdata;
        rso_pkg::REG_UPPER_OFFSET: upper_offset_nxt = cfg_wdata;
        default: ;  // index past the register list, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_width_r   <= rso_pkg::DISP_WIDTH_RST;
      disp_height_r  <= rso_pkg::DISP_HEIGHT_RST;
      upper_offset_r <= rso_pkg::UPPER_OFFSET_RST;
    end else begin
      disp_width_r   <= disp_width_nxt;
      disp_height_r  <= disp_height_nxt;
      upper_offset_r <= upper_offset_nxt;
    end
  end

  // front: overlap test and cut lists, written straight into the queue
  rso_pkg::job_t   front_job, head_job;
  logic            q_full, q_push, q_pop, head_valid;
  rso_pkg::piece_t piece;

  rso_front u_front (
    .rect_x (in_rect_x),
    .rect_y (in_rect_y),
    .rect_w (in_rect_w),
    .rect_h (in_rect_h),
    .occ_x  (in_occ_x),
    .occ_y  (in_occ_y),
    .occ_w  (in_occ_w),
    .occ_h  (in_occ_h),
    .job    (front_job)
  );

  // a transaction lands in the queue whenever there is a free slot
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rso_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (front_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: walks the grid column by column, holds one survivor so that the
  // final piece of each item can be flagged, then registers the result
  rso_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .disp_width   (disp_width_r),
    .disp_height  (disp_height_r),
    .upper_offset (upper_offset_r),
    .job_valid    (head_valid),
    .job          (head_job),
    .job_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_piece    (piece)
  );

  assign out_piece_x    = piece.x;
  assign out_piece_y    = piece.y;
  assign out_piece_w    = piece.w;
  assign out_piece_h    = piece.h;
  assign out_piece_kind = piece.kind;
  assign out_last_piece = piece.last;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for rectangle_split_occlusion_core: a scoreboard splits
// and clips every accepted rectangle pair on its own and compares each piece
// the core emits, under random sender gaps, receiver stalls and screen setups
// ----------------------------------------------------------------------------
module testbench;

  // the core has no name for the fourth register slot; writes to it do nothing
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
  // watchdog: cycles with no transaction, no accepted piece and no register write
  localparam int QUIET_LIMIT = 2000;
  // cycles allowed after the last piece, as margin
  localparam int SETTLE = 12;
  // long receiver hold-offs, started when this many rectangles went in
  localparam int LONG_HOLD = 120;
  localparam int HOLD_AT_A = 60;
  localparam int HOLD_AT_B = 200;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // one input transaction: rectangle to split and its occluder
  typedef struct packed {
    logic [15:0] rx;
    logic [15:0] ry;
    logic [14:0] rw;
    logic [14:0] rh;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [14:0] ow;
    logic [14:0] oh;
  } rect_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_rect_x = '0;
  logic [15:0] in_rect_y = '0;
  logic [14:0] in_rect_w = '0;
  logic [14:0] in_rect_h = '0;
  logic [15:0] in_occ_x = '0;
  logic [15:0] in_occ_y = '0;
  logic [14:0] in_occ_w = '0;
  logic [14:0] in_occ_h = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_piece_x;
  logic [15:0] out_piece_y;
  logic [14:0] out_piece_w;
  logic [14:0] out_piece_h;
  logic [1:0]  out_piece_kind;
  logic        out_last_piece;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_wdata = '0;

  // screen setup as the scoreboard believes it to be
  int screen_w = int'(rso_pkg::DISP_WIDTH_RST);
  int screen_h = int'(rso_pkg::DISP_HEIGHT_RST);
  int upper_off = int'(rso_pkg::UPPER_OFFSET_RST);

  rect_pair_t      pending_rects [$];
  rso_pkg::piece_t expected_pieces [$];
  int              rects_taken = 0;
  int              mismatches = 0;

  always #1 clk = ~clk;

  rectangle_split_occlusion_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_occ_x       (in_occ_x),
    .in_occ_y       (in_occ_y),
    .in_occ_w       (in_occ_w),
    .in_occ_h       (in_occ_h),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_piece_x    (out_piece_x),
    .out_piece_y    (out_piece_y),
    .out_piece_w    (out_piece_w),
    .out_piece_h    (out_piece_h),
    .out_piece_kind (out_piece_kind),
    .out_last_piece (out_last_piece),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // scoreboard model
  // --------------------------------------------------------------------------

  // cut positions along one axis; returns the number of segments
  // x axis keeps the occluder's far edge when it is <= the rectangle's far edge,
  // y axis only when strictly below it
  function automatic int axis_cuts(input int lo, input int len, input int olo,
                                   input int olen, input bit strict_third,
                                   output int cut [4], output int ov);
    int hi;
    int ohi;
    int n;
    bit third;
    hi = lo + len;
    ohi = olo + olen;
    n = 0;
    ov = 0;
    cut[0] = lo;
    cut[1] = 0;
    cut[2] = 0;
    cut[3] = 0;
    if (lo < olo) begin
      if (cut[0] != olo) begin
        n = 1;
        cut[1] = olo;
        ov = 1;
      end
    end else if (cut[0] != ohi) begin
      n = 1;
      cut[1] = (ohi <= hi) ? ohi : hi;
    end
    third = strict_third ? (ohi < hi) : (ohi <= hi);
    if (third && cut[n] != ohi && n < 3) begin
      n++;
      cut[n] = ohi;
    end
    if (cut[n] < hi && n < 3) begin
      n++;
      cut[n] = hi;
    end
    return n;
  endfunction

  // split one rectangle pair, clip to the two screens, queue the pieces
  function automatic void split_and_clip(input rect_pair_t rp);
    int rx, ry, rw, rh, ox, oy, ow, oh;
    int cx [4];
    int cy [4];
    int nx, ny, ovx, ovy, x, y, w, h;
    rso_pkg::piece_t p;
    rso_pkg::piece_t found [$];
    rx = $signed(rp.rx);
    ry = $signed(rp.ry);
    rw = int'(rp.rw);
    rh = int'(rp.rh);
    ox = $signed(rp.ox);
    oy = $signed(rp.oy);
    ow = int'(rp.ow);
    oh = int'(rp.oh);
    p = '0;
    // disjoint pair: the rectangle passes through untouched, even if empty
    if (!(rx + rw > ox && ry + rh > oy && rx < ox + ow && ry < oy + oh)) begin
      p.x = rp.rx;
      p.y = rp.ry;
      p.w = rp.rw;
      p.h = rp.rh;
      p.kind = rso_pkg::KIND_REMAIN;
      p.last = 1'b1;
      expected_pieces.insert(expected_pieces.size(), p);
      return;
    end
    nx = axis_cuts(rx, rw, ox, ow, 1'b0, cx, ovx);
    ny = axis_cuts(ry, rh, oy, oh, 1'b1, cy, ovy);
    // column-major walk over the cut grid
    for (int i = 0; i < nx; i++) begin
      for (int j = 0; j < ny; j++) begin
        x = cx[i];
        y = cy[j];
        w = cx[i + 1] - cx[i];
        h = cy[j + 1] - cy[j];
        if (!(x < screen_w && (y < screen_h ||
              (y >= upper_off && y < upper_off + screen_h))))
          continue;
        if (y + h > screen_h && y + h < upper_off)
          h = screen_h - y;
        else if (y + h > upper_off + screen_h)
          h = upper_off + screen_h - y;
        if (x + w > screen_w)
          w = screen_w - x;
        if (h > 0 && w > 0) begin
          p.x = x[15:0];
          p.y = y[15:0];
          p.w = w[14:0];
          p.h = h[14:0];
          p.kind = (i == ovx && j == ovy) ? rso_pkg::KIND_VISIBLE : rso_pkg::KIND_REMAIN;
          p.last = 1'b0;
          found.insert(found.size(), p);
        end
      end
    end
    // overlap but every piece clipped away
    if (found.size() == 0) begin
      p = '0;
      p.kind = rso_pkg::KIND_NONE;
      found.insert(found.size(), p);
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[k])
      expected_pieces.insert(expected_pieces.size(), found[k]);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_pair(input int rx, input int ry, input int rw, input int rh,
                          input int ox, input int oy, input int ow, input int oh);
    rect_pair_t rp;
    rp.rx = 16'(rx);
    rp.ry = 16'(ry);
    rp.rw = 15'(rw);
    rp.rh = 15'(rh);
    rp.ox = 16'(ox);
    rp.oy = 16'(oy);
    rp.ow = 15'(ow);
    rp.oh = 15'(oh);
    pending_rects.insert(pending_rects.size(), rp);
  endtask

  // mostly overlapping pairs scaled to the current screens, some with shared
  // edges, some independent, and a few with every bit random
  function automatic rect_pair_t random_pair();
    rect_pair_t rp;
    int span, pick, rx, ry, rw, rh, ox, oy, ow, oh;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      rp.rx = 16'($urandom);
      rp.ry = 16'($urandom);
      rp.rw = 15'($urandom);
      rp.rh = 15'($urandom);
      rp.ox = 16'($urandom);
      rp.oy = 16'($urandom);
      rp.ow = 15'($urandom);
      rp.oh = 15'($urandom);
      return rp;
    end
    span = upper_off + screen_h;
    if (screen_w > span)
      span = screen_w;
    if (span < 16)
      span = 16;
    if (span > 20000)
      span = 20000;
    rx = int'($urandom_range(0, span + span / 4)) - span / 8;
    ry = int'($urandom_range(0, span + span / 4)) - span / 8;
    rw = $urandom_range(0, span / 2);
    rh = $urandom_range(0, span / 2);
    if (pick < 85) begin
      ox = rx + int'($urandom_range(0, rw)) - int'($urandom_range(0, rw / 2 + 4));
      oy = ry + int'($urandom_range(0, rh)) - int'($urandom_range(0, rh / 2 + 4));
      ow = $urandom_range(0, rw + 4);
      oh = $urandom_range(0, rh + 4);
      // shared edges hit the split quirks
      case ($urandom_range(0, 4))
        0: ox = rx;
        1: if (rx + rw - ox >= 0) ow = rx + rw - ox;
        2: oy = ry;
        3: if (ry + rh - oy >= 0) oh = ry + rh - oy;
        default: ;
      endcase
    end else begin
      ox = int'($urandom_range(0, span + span / 4)) - span / 8;
      oy = int'($urandom_range(0, span + span / 4)) - span / 8;
      ow = $urandom_range(0, span / 2);
      oh = $urandom_range(0, span / 2);
    end
    rp.rx = 16'(rx);
    rp.ry = 16'(ry);
    rp.rw = 15'(rw);
    rp.rh = 15'(rh);
    rp.ox = 16'(ox);
    rp.oy = 16'(oy);
    rp.ow = 15'(ow);
    rp.oh = 15'(oh);
    return rp;
  endfunction

  // register write at the falling edge; the scoreboard copy follows it
  task automatic write_cfg(input logic [1:0] idx, input logic [14:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      rso_pkg::REG_DISP_WIDTH:   screen_w = int'(value);
      rso_pkg::REG_DISP_HEIGHT:  screen_h = int'(value);
      rso_pkg::REG_UPPER_OFFSET: upper_off = int'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [14:0] random_cfg(input int lo_bound);
    if ($urandom_range(0, 7) == 0)
      return 15'($urandom);
    return 15'($urandom_range(lo_bound, 512));
  endfunction

  // all rectangles sent and every piece back
  task automatic wait_drained();
    while (pending_rects.size() != 0 || expected_pieces.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_random(input int count);
    repeat (count) pending_rects.insert(pending_rects.size(), random_pair());
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset screens 256 / 192 / 192
    add_pair(10, 10, 20, 20, 100, 100, 10, 10);          // disjoint
    add_pair(10, 10, 0, 0, 10, 10, 5, 5);                // empty rect, disjoint
    add_pair(40, 40, 10, 10, 0, 0, 100, 100);            // inside occluder
    add_pair(0, 0, 100, 100, 30, 30, 20, 20);            // full 3x3 grid
    add_pair(0, 0, 100, 100, 50, 50, 50, 50);            // shared far edges
    add_pair(0, 0, 100, 100, 0, 0, 50, 50);              // shared near edges
    add_pair(0, 0, 100, 100, 50, 0, 50, 100);            // x far edge equal
    add_pair(300, 10, 50, 50, 310, 20, 10, 10);          // off screen: nothing left
    add_pair(200, 150, 100, 100, 220, 170, 20, 20);      // width trim
    add_pair(-50, -50, 200, 200, 0, 0, 10, 10);          // negative corner
    add_pair(0, 380, 50, 50, 10, 390, 10, 10);           // height trim at upper end
    add_pair(0, 0, 50, 50, 20, -10, 0, 100);             // zero-width occluder
    add_pair(-32768, -32768, 0, 0, -32768, -32768, 0, 0);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, 0, 32767, 100, -32768, 0, 32767, 50);
    add_pair(0, 0, 32767, 32767, 100, 100, 1, 1);
    add_pair(255, 191, 1, 1, 0, 0, 300, 300);            // last visible pixel
    add_pair(256, 0, 10, 10, 250, 0, 20, 20);            // x at width: dropped
    wait_drained();

    // largest screens; cut past 32767 wraps piece_y
    write_cfg(rso_pkg::REG_DISP_WIDTH, 15'h7fff);
    write_cfg(rso_pkg::REG_DISP_HEIGHT, 15'h7fff);
    write_cfg(rso_pkg::REG_UPPER_OFFSET, 15'h7fff);
    add_pair(0, 32700, 10, 200, 0, 32700, 10, 100);
    add_pair(-32768, -32768, 32767, 32767, -100, -100, 200, 200);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_random(50);
    wait_drained();

    // smallest screens; unnamed register slot must be ignored
    write_cfg(rso_pkg::REG_DISP_WIDTH, 15'd1);
    write_cfg(rso_pkg::REG_DISP_HEIGHT, 15'd1);
    write_cfg(rso_pkg::REG_UPPER_OFFSET, 15'd0);
    write_cfg(CFG_IDX_UNUSED, 15'h7fff);
    add_random(40);
    wait_drained();

    // gap between the two screens
    write_cfg(rso_pkg::REG_DISP_WIDTH, 15'd256);
    write_cfg(rso_pkg::REG_DISP_HEIGHT, 15'd100);
    write_cfg(rso_pkg::REG_UPPER_OFFSET, 15'd150);
    add_pair(0, 80, 50, 100, 10, 90, 10, 10);
    add_random(70);
    wait_drained();

    // random screen setups
    repeat (4) begin
      write_cfg(rso_pkg::REG_DISP_WIDTH, random_cfg(1));
      write_cfg(rso_pkg::REG_DISP_HEIGHT, random_cfg(1));
      write_cfg(rso_pkg::REG_UPPER_OFFSET, random_cfg(0));
      add_random(20);
      wait_drained();
    end

    if (mismatches == 0 && expected_pieces.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // transaction taken: predict its pieces from what is on the port
  always @(posedge clk) begin : rect_sample
    rect_pair_t taken;
    if (rst_n && in_valid && !in_stall) begin
      taken.rx = in_rect_x;
      taken.ry = in_rect_y;
      taken.rw = in_rect_w;
      taken.rh = in_rect_h;
      taken.ox = in_occ_x;
      taken.oy = in_occ_y;
      taken.ow = in_occ_w;
      taken.oh = in_occ_h;
      split_and_clip(taken);
      rects_taken++;
    end
  end

  // driver: bursts of random length separated by random gaps
  int sent_count = 0;
  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk) begin : rect_drive
    bit took;
    took = (rects_taken != sent_count);
    sent_count = rects_taken;
    if (took) begin
      void'(pending_rects.pop_front());
      if (burst_left > 0)
        burst_left--;
      // end of burst: a quarter of the time go straight on
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      end
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      // held: payload stays put
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_rects.size() != 0) begin
      in_valid <= 1'b1;
      in_rect_x <= pending_rects[0].rx;
      in_rect_y <= pending_rects[0].ry;
      in_rect_w <= pending_rects[0].rw;
      in_rect_h <= pending_rects[0].rh;
      in_occ_x <= pending_rects[0].ox;
      in_occ_y <= pending_rects[0].oy;
      in_occ_w <= pending_rects[0].ow;
      in_occ_h <= pending_rects[0].oh;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t piece %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : piece_check
    rso_pkg::piece_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pieces.size() == 0) begin
        $display({"%0t unexpected piece: expected none actual ",
                  "x=%0d y=%0d w=%0d h=%0d kind=%0d last=%0d"},
                 $time, out_piece_x, out_piece_y, out_piece_w, out_piece_h,
                 out_piece_kind, out_last_piece);
        mismatches++;
      end else begin
        want = expected_pieces.pop_front();
        check_field("x", want.x, out_piece_x);
        check_field("y", want.y, out_piece_y);
        check_field("w", want.w, out_piece_w);
        check_field("h", want.h, out_piece_h);
        check_field("kind", want.kind, out_piece_kind);
        check_field("last", want.last, out_last_piece);
      end
    end
  end

  // receiver stall pattern, switched at random; two long hold-offs fill the
  // core while the sender keeps offering
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;
  int last_hold_at = -1;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((rects_taken == HOLD_AT_A || rects_taken == HOLD_AT_B) &&
                 rects_taken != last_hold_at) begin
      last_hold_at = rects_taken;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        STALL_TOGGLE: out_stall <= ~out_stall;
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule
